>>> rtl/tdfa_pkg.sv
`default_nettype none
package tdfa_pkg;

    localparam int MAX_STATES_DEF  = 16;
    localparam int MAX_SYMBOLS_DEF = 4;
    localparam int LABEL_WIDTH_DEF = 8;

    localparam int ACTION_W       = 3;
    localparam int INDEX_W        = 4;
    localparam int SLOT_W         = 2;
    localparam int VALUE_W        = 8;
    localparam int END_LABEL_W    = 8;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 8;
    localparam int STATE_COUNT_W  = 5;
    localparam int SYMBOL_COUNT_W = 3;

    typedef logic [ACTION_W-1:0] action_t;

    localparam action_t ACT_LOAD_STATE      = 3'd0;
    localparam action_t ACT_LOAD_SYMBOL     = 3'd1;
    localparam action_t ACT_LOAD_TRANSITION = 3'd2;
    localparam action_t ACT_STRING_SYMBOL   = 3'd3;
    localparam action_t ACT_EMPTY_STRING    = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_STATE_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOL_COUNT = 2'd1;

    localparam logic [STATE_COUNT_W-1:0]  STATE_COUNT_RST  = 5'd1;
    localparam logic [SYMBOL_COUNT_W-1:0] SYMBOL_COUNT_RST = 3'd2;

    typedef struct packed {
        logic take;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic start_step;
        logic report_pending;
        logic out_busy;
    } ctrl_sts_t;

endpackage
`default_nettype wire

>>> rtl/tdfa_if.sv
`default_nettype none
interface tdfa_item_if;
    import tdfa_pkg::*;

    logic                valid;
    logic                ready;
    action_t             action;
    logic [INDEX_W-1:0]  entry_index;
    logic [SLOT_W-1:0]   symbol_slot;
    logic [VALUE_W-1:0]  value;
    logic                accepting_flag;
    logic                last_symbol;

    modport source (output valid, action, entry_index, symbol_slot, value,
                    accepting_flag, last_symbol, input ready);
    modport sink   (input valid, action, entry_index, symbol_slot, value,
                    accepting_flag, last_symbol, output ready);
endinterface

interface tdfa_result_if;
    import tdfa_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   accepted;
    logic [END_LABEL_W-1:0] end_label;

    modport source (output valid, accepted, end_label, input ready);
    modport sink   (input valid, accepted, end_label, output ready);
endinterface

interface tdfa_cfg_if;
    import tdfa_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/tdfa_ctrl.sv
`default_nettype none
module tdfa_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire tdfa_pkg::ctrl_sts_t  sts,
    output tdfa_pkg::ctrl_cmd_t       cmd
);
    import tdfa_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_STEP = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.take = 1'b1;
                    if (sts.start_step)
                    begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP:
            begin
                // hold while the result word cannot be placed
                if (!(sts.report_pending && sts.out_busy))
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/tdfa_datapath.sv
`default_nettype none
module tdfa_datapath #(
    parameter int MAX_STATES  = tdfa_pkg::MAX_STATES_DEF,
    parameter int MAX_SYMBOLS = tdfa_pkg::MAX_SYMBOLS_DEF,
    parameter int LABEL_WIDTH = tdfa_pkg::LABEL_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tdfa_pkg::ctrl_cmd_t               cmd,
    output tdfa_pkg::ctrl_sts_t                    sts,
    input  wire tdfa_pkg::action_t                 action,
    input  wire logic [tdfa_pkg::INDEX_W-1:0]      entry_index,
    input  wire logic [tdfa_pkg::SLOT_W-1:0]       symbol_slot,
    input  wire logic [tdfa_pkg::VALUE_W-1:0]      value,
    input  wire logic                              accepting_flag,
    input  wire logic                              last_symbol,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output logic                                   accepted,
    output logic [tdfa_pkg::END_LABEL_W-1:0]       end_label,
    input  wire logic                              cfg_valid,
    input  wire logic [tdfa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [tdfa_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tdfa_pkg::*;

    localparam int CELLS  = MAX_STATES * MAX_SYMBOLS;
    localparam int SW     = $clog2(MAX_STATES);
    localparam int SIW    = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int AW     = $clog2(CELLS);
    localparam int WIDE_W = AW + INDEX_W + SLOT_W;
    localparam int LW     = LABEL_WIDTH;

    logic [STATE_COUNT_W-1:0]  state_count_reg;
    logic [SYMBOL_COUNT_W-1:0] symbol_count_reg;

    logic [LW-1:0]      state_labels_reg [MAX_STATES];
    logic               accepting_marks_reg [MAX_STATES];
    logic [VALUE_W-1:0] symbol_values_reg [MAX_SYMBOLS];
    logic [LW-1:0]      next_labels_mem [CELLS];
    logic [LW-1:0]      rd_data_reg;

    logic [SW-1:0] cur_reg;
    logic          hit_reg;
    logic          report_reg;
    logic          empty_reg;
    logic          res_valid_reg;
    logic          accepted_reg;
    logic [END_LABEL_W-1:0] end_label_reg;

    logic [LW+VALUE_W-1:0]     value_ext;
    logic [LW-1:0]             label_in;
    logic                      sym_hit;
    logic [SIW-1:0]            sym_idx;
    logic [WIDE_W-1:0]         wr_cell;
    logic [WIDE_W-1:0]         rd_cell;
    logic                      tr_we;
    logic                      rd_en;
    logic                      lab_found;
    logic [SW-1:0]             lab_idx;
    logic [SW-1:0]             cur_step;
    logic [SW-1:0]             q;
    logic [LW+END_LABEL_W-1:0] end_ext;

    assign value_ext = {LW'(0), value};
    assign label_in  = value_ext[LW-1:0];

    always_comb
    begin
        sym_hit = 1'b0;
        sym_idx = '0;
        for (int t = MAX_SYMBOLS - 1; t >= 0; t--)
        begin
            if (t < symbol_count_reg && symbol_values_reg[t] == value)
            begin
                sym_hit = 1'b1;
                sym_idx = SIW'(t);
            end
        end
    end

    assign wr_cell = WIDE_W'(entry_index) * WIDE_W'(MAX_SYMBOLS) + WIDE_W'(symbol_slot);
    assign rd_cell = WIDE_W'(cur_reg) * WIDE_W'(MAX_SYMBOLS) + WIDE_W'(sym_idx);
    assign tr_we   = cmd.take && action == ACT_LOAD_TRANSITION
                     && entry_index < MAX_STATES && symbol_slot < MAX_SYMBOLS;
    assign rd_en   = cmd.take && action == ACT_STRING_SYMBOL && sym_hit;

    always_ff @(posedge clk)
    begin
        if (tr_we)
        begin
            next_labels_mem[wr_cell[AW-1:0]] <= label_in;
        end
        if (rd_en)
        begin
            rd_data_reg <= next_labels_mem[rd_cell[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_STATES; k++)
        begin
            if (cmd.take && action == ACT_LOAD_STATE && entry_index == k)
            begin
                state_labels_reg[k] <= label_in;
            end
        end
        for (int t = 0; t < MAX_SYMBOLS; t++)
        begin
            if (cmd.take && action == ACT_LOAD_SYMBOL && entry_index == t)
            begin
                symbol_values_reg[t] <= value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_STATES; k++)
            begin
                accepting_marks_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < MAX_STATES; k++)
            begin
                if (cmd.take && action == ACT_LOAD_STATE && entry_index == k)
                begin
                    accepting_marks_reg[k] <= accepting_flag;
                end
            end
        end
    end

    always_comb
    begin
        lab_found = 1'b0;
        lab_idx   = '0;
        for (int j = MAX_STATES - 1; j >= 0; j--)
        begin
            if (j < state_count_reg && state_labels_reg[j] == rd_data_reg)
            begin
                lab_found = 1'b1;
                lab_idx   = SW'(j);
            end
        end
    end

    assign cur_step = (hit_reg && lab_found) ? lab_idx : cur_reg;
    assign q        = empty_reg ? '0 : cur_step;
    assign end_ext  = {END_LABEL_W'(0), state_labels_reg[q]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_count_reg  <= STATE_COUNT_RST;
            symbol_count_reg <= SYMBOL_COUNT_RST;
            cur_reg          <= '0;
            hit_reg          <= 1'b0;
            report_reg       <= 1'b0;
            empty_reg        <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_STATE_COUNT)
            begin
                state_count_reg <= cfg_data[STATE_COUNT_W-1:0];
            end
            if (cfg_valid && cfg_index == CFG_SYMBOL_COUNT)
            begin
                symbol_count_reg <= cfg_data[SYMBOL_COUNT_W-1:0];
            end
            if (cmd.take)
            begin
                hit_reg    <= action == ACT_STRING_SYMBOL && sym_hit;
                report_reg <= action == ACT_EMPTY_STRING || last_symbol;
                empty_reg  <= action == ACT_EMPTY_STRING;
            end
            if (cmd.commit)
            begin
                cur_reg <= report_reg ? '0 : cur_step;
            end
            if (cmd.commit && report_reg)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && report_reg)
        begin
            accepted_reg  <= accepting_marks_reg[q];
            end_label_reg <= end_ext[END_LABEL_W-1:0];
        end
    end

    assign sts.start_step     = action == ACT_STRING_SYMBOL || action == ACT_EMPTY_STRING;
    assign sts.report_pending = report_reg;
    assign sts.out_busy       = res_valid_reg && !res_ready;

    assign res_valid = res_valid_reg;
    assign accepted  = accepted_reg;
    assign end_label = end_label_reg;

endmodule
`default_nettype wire

>>> rtl/table_driven_dfa_acceptor_top.sv
// Programmable table-driven DFA string acceptor.
// Channels: items (valid/ready) carries load and string words, results
// (valid/ready) carries one word per finished string, cfg (valid/ready,
// always ready) writes state_count (index 0) and symbol_count (index 1).
// Load words (state, symbol, transition) are taken without leaving the
// idle state; codes 5 to 7 are taken and dropped. A string symbol word is
// taken and then passes the step state: the symbol is matched against the
// first symbol_count symbol values while the transition memory is read,
// then the registered next label is matched against the first state_count
// state labels and the current state is updated (reset to 0 at string end).
// An empty-string word reports from state 0. A result word is registered
// when the step state commits after the last symbol or empty-string word
// and stays in the output register until taken; while it waits, loads are
// taken; a word that ends a string holds in the step state until it is taken.
// Reset clears the accepting marks, the current state and the output valid
// flag and restores state_count = 1, symbol_count = 2; labels, symbol
// values and transitions are undefined until loaded.
`default_nettype none
module table_driven_dfa_acceptor_top #(
    parameter int MAX_STATES  = tdfa_pkg::MAX_STATES_DEF,
    parameter int MAX_SYMBOLS = tdfa_pkg::MAX_SYMBOLS_DEF,
    parameter int LABEL_WIDTH = tdfa_pkg::LABEL_WIDTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tdfa_item_if.sink     items,
    tdfa_result_if.source results,
    tdfa_cfg_if.sink      cfg
);
    import tdfa_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    logic      item_ready;

    tdfa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (items.valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    tdfa_datapath #(
        .MAX_STATES  (MAX_STATES),
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .LABEL_WIDTH (LABEL_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .action         (items.action),
        .entry_index    (items.entry_index),
        .symbol_slot    (items.symbol_slot),
        .value          (items.value),
        .accepting_flag (items.accepting_flag),
        .last_symbol    (items.last_symbol),
        .res_valid      (results.valid),
        .res_ready      (results.ready),
        .accepted       (results.accepted),
        .end_label      (results.end_label),
        .cfg_valid      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data)
    );

    assign items.ready = item_ready;
    assign cfg.ready   = 1'b1;

    a_empty_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready && items.action == ACT_EMPTY_STRING && !results.valid)
        |-> ##2 results.valid)
        else $error("empty-string word gave no result");

    a_load_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready && (items.action == ACT_LOAD_STATE
            || items.action == ACT_LOAD_SYMBOL || items.action == ACT_LOAD_TRANSITION))
        |=> items.ready)
        else $error("load word stalled the item channel");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && sts.report_pending) |-> !sts.out_busy)
        else $error("result written over a pending word");

endmodule
`default_nettype wire
